/* src/tasg_pkg.sv */
package tasg_pkg;

    localparam int NUM_AXES = 3;
    localparam int POS_W    = 24;
    localparam int SPM_W    = 20;
    localparam int TIME_W   = 32;
    localparam int FEED_W   = 16;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_SETPOS = 2'd2,
        FUNC_STOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_X_SPM   = 2'd0,
        REG_Y_SPM   = 2'd1,
        REG_Z_SPM   = 2'd2,
        REG_MIN_INT = 2'd3
    } reg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SETPOS,
        OP_STOP,
        OP_START_LOAD,
        OP_SQRT_STEP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_START_FINISH,
        OP_EVENT,
        OP_RAMP_LOAD,
        OP_RAMP_STEP,
        OP_RAMP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic due;
        logic zero_events;
        logic move_finished;
    } status_t;

endpackage

/* src/tasg_if.sv */
interface tasg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] now_us;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;
    logic [15:0] feedrate;

    modport source (output valid, func, now_us, target_x, target_y, target_z, feedrate,
                    input ready);
    modport sink (input valid, func, now_us, target_x, target_y, target_z, feedrate,
                  output ready);
endinterface

interface tasg_out_if;
    logic valid;
    logic ready;
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic motors_enabled;
    logic busy_res;
    logic move_done;
    logic accepted;

    modport source (output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                    motors_enabled, busy_res, move_done, accepted, input ready);
    modport sink (input valid, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                  motors_enabled, busy_res, move_done, accepted, output ready);
endinterface

interface tasg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/three_axis_step_generator_core.sv */
// Three-axis step generator. One result beat per input beat. For a tick that is not
// due, a set-position, a stop or a refused start the result is valid in the cycle
// after the beat is taken; a zero-length start and the event that ends a move go
// through S_SQRT or S_RAMP and then S_OUT; a start move runs 32 square-root steps,
// then 64 restoring-divide steps for the base interval; a tick that runs a step event
// runs a 64-step ramp divide in the shared iterative unit. A new beat is taken once the
// previous result has been accepted or is being accepted.
module three_axis_step_generator_core #(
    parameter int COUNT_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    tasg_in_if.sink    in_ch,
    tasg_out_if.source out_ch,
    tasg_cfg_if.sink   cfg
);
    tasg_pkg::cmd_t    cmd;
    tasg_pkg::status_t status;
    logic [2:0] step, dir;
    logic motors, busy;

    assign cfg.ready = 1'b1;

    tasg_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .func(in_ch.func),
        .status, .cmd,
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .move_done(out_ch.move_done), .accepted(out_ch.accepted)
    );

    tasg_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .clk, .rst_n, .cmd, .status,
        .now_us(in_ch.now_us),
        .target_x(in_ch.target_x), .target_y(in_ch.target_y), .target_z(in_ch.target_z),
        .feedrate(in_ch.feedrate),
        .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
        .step, .dir, .motors_enabled(motors), .busy
    );

    assign out_ch.step_x = step[0];
    assign out_ch.step_y = step[1];
    assign out_ch.step_z = step[2];
    assign out_ch.dir_x  = dir[0];
    assign out_ch.dir_y  = dir[1];
    assign out_ch.dir_z  = dir[2];
    assign out_ch.motors_enabled = motors;
    assign out_ch.busy_res = busy;
endmodule

/* src/tasg_datapath.sv */
module tasg_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tasg_pkg::cmd_t      cmd,
    output tasg_pkg::status_t   status,
    input  logic [31:0]         now_us,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  logic signed [23:0]  target_z,
    input  logic [15:0]         feedrate,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    output logic [2:0]          step,
    output logic [2:0]          dir,
    output logic                motors_enabled,
    output logic                busy
);
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    logic [19:0] spm_reg [3];
    logic [19:0] min_int_reg;

    logic        active_reg, motor_reg;
    logic [2:0]  dir_reg;
    logic signed [23:0] cur_reg [3];
    logic signed [23:0] tgt_reg [3];
    logic [CW-1:0] steps_reg [3];
    logic [CW-1:0] accum_reg [3];
    logic [CW-1:0] total_reg, done_reg;
    logic [CW-1:0] ramp_reg;
    logic [31:0] base_reg, due_reg;
    logic [2:0]  step_reg;
    logic [31:0] now_reg;
    logic [15:0] feed_reg;

    // shared iterative unit: sqrt then restoring divide
    logic [63:0] sq_reg;      // radicand remainder
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [95:0] num_reg;     // dividend / quotient shift register
    logic [63:0] rem_reg;
    logic [63:0] den_reg;

    logic signed [23:0] tgt_in [3];
    assign tgt_in[0] = target_x;
    assign tgt_in[1] = target_y;
    assign tgt_in[2] = target_z;

    logic [24:0] mag [3];
    logic signed [24:0] dlt [3];
    logic [44:0] prod [3];
    logic [CW-1:0] sat_s [3];
    logic [CW-1:0] maxs;
    logic [49:0] sqsum;

    always_comb
    begin
        maxs  = '0;
        sqsum = '0;
        for (int i = 0; i < 3; i++)
        begin
            dlt[i]  = 25'(tgt_in[i]) - 25'(cur_reg[i]);
            mag[i]  = dlt[i][24] ? 25'(-dlt[i]) : 25'(dlt[i]);
            prod[i] = 45'(mag[i]) * 45'(spm_reg[i]) + 45'd32768;
            if (prod[i][44:16] > 29'(CMAX))
                sat_s[i] = CMAX;
            else
                sat_s[i] = CW'(prod[i][44:16]);
            if (sat_s[i] > maxs)
                maxs = sat_s[i];
            sqsum = sqsum + 50'(mag[i]) * 50'(mag[i]);
        end
    end

    // total / 5 by reciprocal multiplication, exact for 32-bit counts
    logic [63:0] fifth_prod;
    assign fifth_prod = 64'(total_reg) * 64'd3435973837;

    // ramp arithmetic
    logic [CW-1:0] rpos, remain;
    logic [CW+1:0] rfac;
    assign remain = total_reg - done_reg;
    always_comb
    begin
        if (done_reg < ramp_reg)
            rpos = done_reg + 1'b1;
        else if (remain < ramp_reg)
            rpos = remain;
        else
            rpos = ramp_reg;
        rfac = {ramp_reg, 1'b0} - (CW+1)'(rpos);
    end

    logic [63:0] trial;
    logic [64:0] rtrial;
    assign trial  = root_reg + bit_reg;
    assign rtrial = {rem_reg, num_reg[95]};

    logic [CW-1:0] acc_sum [3];
    logic [CW:0]   acc_wide [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_wide[i] = (CW+1)'(accum_reg[i]) + (CW+1)'(steps_reg[i]);
            acc_sum[i]  = acc_wide[i] >= (CW+1)'(total_reg)
                        ? CW'(acc_wide[i] - (CW+1)'(total_reg)) : CW'(acc_wide[i]);
        end
    end

    logic [63:0] qv;
    assign qv = num_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_reg[0] <= 20'd20480;
            spm_reg[1] <= 20'd20480;
            spm_reg[2] <= 20'd20480;
            min_int_reg <= 20'd1200;
            active_reg <= 1'b0;
            motor_reg  <= 1'b0;
            dir_reg    <= 3'b111;
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]   <= '0;
                tgt_reg[i]   <= '0;
                steps_reg[i] <= '0;
                accum_reg[i] <= '0;
            end
            total_reg <= '0;
            done_reg  <= '0;
            ramp_reg  <= '0;
            base_reg  <= '0;
            due_reg   <= '0;
            step_reg  <= '0;
            now_reg   <= '0;
            feed_reg  <= '0;
            sq_reg    <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tasg_pkg::REG_X_SPM:   spm_reg[0] <= cfg_data;
                    tasg_pkg::REG_Y_SPM:   spm_reg[1] <= cfg_data;
                    tasg_pkg::REG_Z_SPM:   spm_reg[2] <= cfg_data;
                    tasg_pkg::REG_MIN_INT: min_int_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                tasg_pkg::OP_CLEAR:
                    step_reg <= '0;
                tasg_pkg::OP_SETPOS:
                begin
                    step_reg <= '0;
                    for (int i = 0; i < 3; i++)
                        cur_reg[i] <= tgt_in[i];
                end
                tasg_pkg::OP_STOP:
                begin
                    step_reg   <= '0;
                    active_reg <= 1'b0;
                    motor_reg  <= 1'b0;
                end
                tasg_pkg::OP_START_LOAD:
                begin
                    step_reg  <= '0;
                    motor_reg <= 1'b1;
                    now_reg   <= now_us;
                    feed_reg  <= (feedrate == 16'd0) ? 16'd1 : feedrate;
                    for (int i = 0; i < 3; i++)
                    begin
                        steps_reg[i] <= sat_s[i];
                        accum_reg[i] <= '0;
                        dir_reg[i]   <= ~dlt[i][24];
                        tgt_reg[i]   <= tgt_in[i];
                    end
                    total_reg <= maxs;
                    done_reg  <= '0;
                    base_reg  <= '0;
                    due_reg   <= '0;
                    if (maxs == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                            cur_reg[i] <= tgt_in[i];
                    end
                    sq_reg   <= {2'b0, sqsum, 12'b0};
                    root_reg <= '0;
                    bit_reg  <= 64'h4000_0000_0000_0000;
                end
                tasg_pkg::OP_SQRT_STEP:
                begin
                    if (sq_reg >= trial)
                    begin
                        sq_reg   <= sq_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                tasg_pkg::OP_DIV_LOAD:
                begin
                    // dist * 60e6 fits in 64 bits; denominator below 2^62
                    num_reg  <= {64'(root_reg[31:0]) * 64'd60000000, 32'b0};
                    rem_reg  <= '0;
                    den_reg  <= (64'(feed_reg) * 64'(total_reg)) << 14;
                    ramp_reg <= CW'(fifth_prod[63:34]);
                    bit_reg  <= 64'd64;
                end
                tasg_pkg::OP_RAMP_LOAD:
                begin
                    num_reg <= {64'(base_reg) * 64'(rfac), 32'b0};
                    rem_reg <= '0;
                    den_reg <= 64'(ramp_reg);
                    bit_reg <= 64'd64;
                end
                tasg_pkg::OP_DIV_STEP, tasg_pkg::OP_RAMP_STEP:
                begin
                    if (rtrial >= 65'(den_reg))
                    begin
                        rem_reg <= 64'(rtrial - 65'(den_reg));
                        num_reg <= {num_reg[94:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rtrial[63:0];
                        num_reg <= {num_reg[94:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                end
                tasg_pkg::OP_START_FINISH:
                begin
                    if (qv[63:32] != '0)
                        base_reg <= 32'hFFFF_FFFF;
                    else if (qv[31:0] < 32'(min_int_reg))
                        base_reg <= 32'(min_int_reg);
                    else
                        base_reg <= qv[31:0];
                    due_reg    <= now_reg;
                    active_reg <= 1'b1;
                end
                tasg_pkg::OP_EVENT:
                begin
                    now_reg <= now_us;
                    for (int i = 0; i < 3; i++)
                    begin
                        accum_reg[i] <= acc_sum[i];
                        step_reg[i]  <= acc_wide[i] >= (CW+1)'(total_reg);
                    end
                    done_reg <= done_reg + 1'b1;
                    if (done_reg + 1'b1 >= total_reg)
                    begin
                        active_reg <= 1'b0;
                        for (int i = 0; i < 3; i++)
                            cur_reg[i] <= tgt_reg[i];
                    end
                end
                tasg_pkg::OP_RAMP_FINISH:
                begin
                    if (ramp_reg <= CW'(1))
                        due_reg <= now_reg + base_reg;
                    else if (qv[63:32] != '0)
                        due_reg <= now_reg + 32'hFFFF_FFFF;
                    else
                        due_reg <= now_reg + qv[31:0];
                end
                default: ;
            endcase
        end
    end

    assign status.active        = active_reg;
    assign status.due           = ~(now_us - due_reg) >> 31 == 32'd1;
    assign status.zero_events   = (total_reg == '0);
    assign status.move_finished = ~active_reg;

    assign step           = step_reg;
    assign dir            = dir_reg;
    assign motors_enabled = motor_reg;
    assign busy           = active_reg;
endmodule

/* src/tasg_ctrl.sv */
module tasg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  tasg_pkg::status_t  status,
    output tasg_pkg::cmd_t     cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               move_done,
    output logic               accepted
);
    typedef enum logic [2:0] {
        S_IDLE, S_SQRT, S_DIV, S_SFIN, S_RAMP, S_RDIV, S_RFIN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       done_reg, done_next;
    logic       acc_reg, acc_next;
    tasg_pkg::op_t op;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        done_next      = done_reg;
        acc_next       = acc_reg;
        op             = tasg_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    done_next = 1'b0;
                    acc_next  = 1'b1;
                    case (func)
                        tasg_pkg::FUNC_TICK:
                            if (status.active && status.due)
                            begin
                                op = tasg_pkg::OP_EVENT;
                                state_next = S_RAMP;
                            end
                            else
                            begin
                                op = tasg_pkg::OP_CLEAR;
                                out_valid_next = 1'b1;
                            end
                        tasg_pkg::FUNC_START:
                            if (status.active)
                            begin
                                op = tasg_pkg::OP_CLEAR;
                                acc_next = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                op = tasg_pkg::OP_START_LOAD;
                                state_next = S_SQRT;
                                cnt_next = '0;
                            end
                        tasg_pkg::FUNC_SETPOS:
                        begin
                            op = tasg_pkg::OP_SETPOS;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            op = tasg_pkg::OP_STOP;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            S_SQRT:
                if (status.zero_events)
                begin
                    done_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    op = tasg_pkg::OP_SQRT_STEP;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_next = S_DIV;
                        cnt_next = '0;
                    end
                end
            S_DIV:
            begin
                op = (cnt_reg == 6'd0) ? tasg_pkg::OP_DIV_LOAD : tasg_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                    state_next = S_SFIN;
            end
            S_SFIN:
            begin
                op = tasg_pkg::OP_DIV_STEP;
                state_next = S_RFIN;
                cnt_next = 6'd62;
            end
            S_RAMP:
                if (status.move_finished)
                begin
                    done_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    op = tasg_pkg::OP_RAMP_LOAD;
                    cnt_next = '0;
                    state_next = S_RDIV;
                end
            S_RDIV:
            begin
                // 64 divide steps for the ramped interval
                op = tasg_pkg::OP_RAMP_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_RFIN;
                    cnt_next = 6'd61;
                end
            end
            S_RFIN:
            begin
                // cnt 62 finishes a start move, cnt 61 a ramp divide
                if (cnt_reg == 6'd62)
                    op = tasg_pkg::OP_START_FINISH;
                else
                    op = tasg_pkg::OP_RAMP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            acc_reg       <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
            acc_reg       <= acc_next;
        end
    end

    assign cmd.op    = op;
    assign out_valid = out_valid_reg;
    assign move_done = done_reg;
    assign accepted  = acc_reg;
endmodule
